>>> src/lpid_pkg.sv
// lpid_pkg: shared types and constants of the led pixel interp/lut/dither unit
// no dependencies; used by every module under src except lpid_ram
package lpid_pkg;

    // color table geometry, split into even and odd entry banks
    localparam int LUT_ENTRIES    = 257;
    localparam int LUT_EVEN_DEPTH = (LUT_ENTRIES + 1) / 2;
    localparam int LUT_ODD_DEPTH  = LUT_ENTRIES / 2;
    localparam int LUT_EVEN_AW    = 8;
    localparam int LUT_ODD_AW     = 7;
    localparam logic [8:0] LUT_LAST_ENTRY = 9'(LUT_ENTRIES - 1);

    // residual word width
    localparam int RES_W = 11;

    // request kinds
    localparam logic OP_PIXEL     = 1'b0;
    localparam logic OP_LUT_WRITE = 1'b1;

    // configuration register indexes
    localparam logic [1:0] CFG_COEF      = 2'd0;
    localparam logic [1:0] CFG_INTERP_EN = 2'd1;
    localparam logic [1:0] CFG_DITHER_EN = 2'd2;

    localparam logic [16:0] COEF_FULL = 17'h10000;

    typedef struct packed {
        logic [16:0] coefficient;
        logic        interp_en;
        logic        dither_en;
    } cfg_t;

    // control and side payload that travels with each request
    typedef struct packed {
        logic        valid;
        logic        op;
        logic [1:0]  lut_channel;
        logic [8:0]  lut_entry;
        logic [15:0] lut_value;
        logic [7:0]  extra;
    } ctl_t;

    typedef logic [2:0][7:0]  chan8_t;
    typedef logic [2:0][15:0] chan16_t;

endpackage

>>> src/led_pixel_interp_lut_dither_unit.sv
// led_pixel_interp_lut_dither_unit: top level, config registers and stream ports
// depends on lpid_pkg, lpid_blend, lpid_lut, lpid_dither, lpid_ram
//
// Usage:
//   s_* carries requests: s_tuser = 0 is a pixel, 1 writes one color table entry.
//   m_* carries one dithered pixel per pixel request; table writes give none.
//   cfg_wr_* writes the blend coefficient and the interp/dither enables; write
//   only while no request is in flight.
// Pipeline: a pixel accepted by s_* is registered in the input stage, then
//   passes the product, blend, table read, interpolation and
//   rounding/output stages before it shows on m_tvalid.
// Throughput: one request per cycle while the pipeline is not stalled; the
//   table banks and residual banks each see one read and one write per cycle,
//   with residual forwarding in place of read-after-write stalls.
// Reset: all control clears; the residual store is then cleared entry by
//   entry, all MAX_PIXELS of them, while s_tready stays low. Table entries must be
//   written before any pixel reads them.
// Stall: while m_tvalid is high and m_tready low the whole pipeline holds and
//   s_tready drops; nothing is lost or repeated.
module led_pixel_interp_lut_dither_unit #(
    parameter int MAX_PIXELS = 512
) (
    input  logic        clk,
    input  logic        rst_n,
    // fields from bit 0: pixel_index[8:0], prev_red, prev_green, prev_blue,
    // next_red, next_green, next_blue, next_extra, lut_channel[1:0],
    // lut_entry[8:0], lut_value[15:0], zero fill
    input  logic [95:0] s_tdata,
    // fields from bit 0: opcode
    input  logic [0:0]  s_tuser,
    input  logic        s_tvalid,
    output logic        s_tready,
    // fields from bit 0: red_out, green_out, blue_out, extra_out
    output logic [31:0] m_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_wr_index,
    input  logic [16:0] cfg_wr_data
);

    localparam int PIX_AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;

    lpid_pkg::cfg_t    cfg_reg;
    lpid_pkg::ctl_t    in_ctl, ctl3, ctl5;
    lpid_pkg::chan8_t  in_prev, in_next, out_color;
    lpid_pkg::chan16_t v16_3, interp5;
    logic [PIX_AW-1:0] pix3;
    logic [7:0]        out_extra;
    logic              en, clearing, out_valid;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.coefficient <= lpid_pkg::COEF_FULL;
            cfg_reg.interp_en   <= 1'b1;
            cfg_reg.dither_en   <= 1'b1;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_wr_index)
                lpid_pkg::CFG_COEF:      cfg_reg.coefficient <= cfg_wr_data;
                lpid_pkg::CFG_INTERP_EN: cfg_reg.interp_en   <= cfg_wr_data[0];
                lpid_pkg::CFG_DITHER_EN: cfg_reg.dither_en   <= cfg_wr_data[0];
                default:                 ;
            endcase
        end
    end

    // pipeline advance and input handshake
    assign en       = !out_valid || m_tready;
    assign s_tready = en && !clearing;

    // unpack the request
    always_comb
    begin
        in_ctl.valid       = s_tvalid && s_tready;
        in_ctl.op          = s_tuser[0];
        in_ctl.lut_channel = s_tdata[66:65];
        in_ctl.lut_entry   = s_tdata[75:67];
        in_ctl.lut_value   = s_tdata[91:76];
        in_ctl.extra       = s_tdata[64:57];
        in_prev[0]         = s_tdata[16:9];
        in_prev[1]         = s_tdata[24:17];
        in_prev[2]         = s_tdata[32:25];
        in_next[0]         = s_tdata[40:33];
        in_next[1]         = s_tdata[48:41];
        in_next[2]         = s_tdata[56:49];
    end

    lpid_blend #(
        .MAX_PIXELS(MAX_PIXELS),
        .AW        (PIX_AW)
    ) u_blend (
        .clk            (clk),
        .rst_n          (rst_n),
        .en             (en),
        .cfg            (cfg_reg),
        .in_ctl         (in_ctl),
        .in_pixel_index (s_tdata[8:0]),
        .in_prev        (in_prev),
        .in_next        (in_next),
        .ctl3           (ctl3),
        .v16_3          (v16_3),
        .pix3           (pix3)
    );

    lpid_lut u_lut (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .cfg     (cfg_reg),
        .ctl3    (ctl3),
        .v16_3   (v16_3),
        .ctl5    (ctl5),
        .interp5 (interp5)
    );

    lpid_dither #(
        .MAX_PIXELS(MAX_PIXELS),
        .AW        (PIX_AW)
    ) u_dither (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .cfg       (cfg_reg),
        .pix3      (pix3),
        .ctl5      (ctl5),
        .interp5   (interp5),
        .clearing  (clearing),
        .out_valid (out_valid),
        .out_color (out_color),
        .out_extra (out_extra)
    );

    assign m_tvalid = out_valid;
    assign m_tdata  = {out_extra, out_color[2], out_color[1], out_color[0]};

endmodule

>>> src/lpid_ram.sv
// lpid_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
module lpid_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> src/lpid_blend.sv
// lpid_blend: input stage, keyframe blend multipliers and pixel index folding
// depends on lpid_pkg
module lpid_blend #(
    parameter int MAX_PIXELS = 512,
    parameter int AW         = 9
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  lpid_pkg::cfg_t    cfg,
    input  lpid_pkg::ctl_t    in_ctl,
    input  logic [8:0]        in_pixel_index,
    input  lpid_pkg::chan8_t  in_prev,
    input  lpid_pkg::chan8_t  in_next,
    output lpid_pkg::ctl_t    ctl3,
    output lpid_pkg::chan16_t v16_3,
    output logic [AW-1:0]     pix3
);

    localparam int RECIP = (1 << 20) / MAX_PIXELS;

    logic [16:0] coef_clamp;
    logic [24:0] wprev_reg, wnext_reg;

    lpid_pkg::ctl_t   ctl1_reg, ctl2_reg, ctl3_reg;
    lpid_pkg::chan8_t prev1_reg, next1_reg, next2_reg;
    logic [8:0]       pix1_reg, pix2_reg;
    logic [9:0]       q2_reg;
    logic [29:0]      pq1;
    logic [2:0][31:0] prodp2_reg, prodn2_reg;
    lpid_pkg::chan16_t v16_next, v16_reg;
    logic [22:0]      r_full, r_corr;
    logic [AW-1:0]    pix3_reg;

    // blend weights 257*(65536-c) and 257*c
    assign coef_clamp = (cfg.coefficient > lpid_pkg::COEF_FULL) ? lpid_pkg::COEF_FULL
                                                                : cfg.coefficient;
    always_ff @(posedge clk)
    begin
        wnext_reg <= {coef_clamp, 8'd0} + 25'(coef_clamp);
        wprev_reg <= {lpid_pkg::COEF_FULL - coef_clamp, 8'd0}
                     + 25'(lpid_pkg::COEF_FULL - coef_clamp);
    end

    // reciprocal estimate of the pixel index quotient
    assign pq1 = 30'(pix1_reg) * 30'(RECIP);

    // 16-bit channel value, and pixel index with one correction step
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            if (cfg.interp_en)
            begin
                v16_next[k] = 16'((prodp2_reg[k] + prodn2_reg[k]) >> 16);
            end
            else
            begin
                v16_next[k] = {next2_reg[k], next2_reg[k]};
            end
        end
        r_full = 23'(pix2_reg) - 23'(q2_reg) * 23'(MAX_PIXELS);
        r_corr = (r_full >= 23'(MAX_PIXELS)) ? r_full - 23'(MAX_PIXELS) : r_full;
    end

    // control pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
            ctl3_reg <= '0;
        end
        else if (en)
        begin
            ctl1_reg <= in_ctl;
            ctl2_reg <= ctl1_reg;
            ctl3_reg <= ctl2_reg;
        end
    end

    // data pipeline
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prev1_reg <= in_prev;
            next1_reg <= in_next;
            pix1_reg  <= in_pixel_index;
            for (int k = 0; k < 3; k++)
            begin
                prodp2_reg[k] <= 32'(prev1_reg[k]) * 32'(wprev_reg);
                prodn2_reg[k] <= 32'(next1_reg[k]) * 32'(wnext_reg);
            end
            next2_reg <= next1_reg;
            pix2_reg  <= pix1_reg;
            q2_reg    <= pq1[29:20];
            v16_reg   <= v16_next;
            pix3_reg  <= AW'(r_corr);
        end
    end

    assign ctl3  = ctl3_reg;
    assign v16_3 = v16_reg;
    assign pix3  = pix3_reg;

endmodule

>>> src/lpid_lut.sv
// lpid_lut: per-channel color table in even/odd banks with linear interpolation
// depends on lpid_pkg and lpid_ram
module lpid_lut (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  lpid_pkg::cfg_t    cfg,
    input  lpid_pkg::ctl_t    ctl3,
    input  lpid_pkg::chan16_t v16_3,
    output lpid_pkg::ctl_t    ctl5,
    output lpid_pkg::chan16_t interp5
);

    lpid_pkg::ctl_t    ctl4_reg, ctl5_reg, ctl4_next;
    logic [2:0]        pos0_reg;
    lpid_pkg::chan8_t  frac_reg;
    lpid_pkg::chan16_t ev_data, od_data, interp_reg;
    logic              wr_ok;

    assign wr_ok = ctl3.valid && (ctl3.op == lpid_pkg::OP_LUT_WRITE)
                   && (ctl3.lut_entry <= lpid_pkg::LUT_LAST_ENTRY);

    // table banks: entry e sits in bank e[0] at address e>>1
    for (genvar k = 0; k < 3; k++)
    begin : g_chan
        logic [7:0] pos;
        logic       wr_chan;
        assign pos     = v16_3[k][15:8];
        assign wr_chan = en && wr_ok && (ctl3.lut_channel == 2'(k));

        lpid_ram #(
            .WIDTH(16),
            .DEPTH(lpid_pkg::LUT_EVEN_DEPTH)
        ) u_even (
            .clk   (clk),
            .we    (wr_chan && !ctl3.lut_entry[0]),
            .waddr (ctl3.lut_entry[8:1]),
            .wdata (ctl3.lut_value),
            .re    (en),
            .raddr (lpid_pkg::LUT_EVEN_AW'((9'(pos) + 9'd1) >> 1)),
            .rdata (ev_data[k])
        );

        lpid_ram #(
            .WIDTH(16),
            .DEPTH(lpid_pkg::LUT_ODD_DEPTH)
        ) u_odd (
            .clk   (clk),
            .we    (wr_chan && ctl3.lut_entry[0]),
            .waddr (ctl3.lut_entry[7:1]),
            .wdata (ctl3.lut_value),
            .re    (en),
            .raddr (pos[7:1]),
            .rdata (od_data[k])
        );
    end

    // table writes end here; only pixel requests go on
    always_comb
    begin
        ctl4_next       = ctl3;
        ctl4_next.valid = ctl3.valid && (ctl3.op == lpid_pkg::OP_PIXEL);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl4_reg <= '0;
            ctl5_reg <= '0;
        end
        else if (en)
        begin
            ctl4_reg <= ctl4_next;
            ctl5_reg <= ctl4_reg;
        end
    end

    // interpolation between the two neighbor entries
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                logic [15:0] lo, hi;
                logic [23:0] acc;
                lo  = pos0_reg[k] ? od_data[k] : ev_data[k];
                hi  = pos0_reg[k] ? ev_data[k] : od_data[k];
                acc = 24'(lo) * 24'(9'd256 - 9'(frac_reg[k])) + 24'(hi) * 24'(frac_reg[k]);
                interp_reg[k] <= acc[23:8];
                pos0_reg[k]   <= v16_3[k][8];
                frac_reg[k]   <= cfg.interp_en ? v16_3[k][7:0] : 8'd0;
            end
        end
    end

    assign ctl5    = ctl5_reg;
    assign interp5 = interp_reg;

endmodule

>>> src/lpid_dither.sv
// lpid_dither: residual store, clearing pass, forwarding, rounding and output register
// depends on lpid_pkg and lpid_ram
module lpid_dither #(
    parameter int MAX_PIXELS = 512,
    parameter int AW         = 9
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  lpid_pkg::cfg_t    cfg,
    input  logic [AW-1:0]     pix3,
    input  lpid_pkg::ctl_t    ctl5,
    input  lpid_pkg::chan16_t interp5,
    output logic              clearing,
    output logic              out_valid,
    output lpid_pkg::chan8_t  out_color,
    output logic [7:0]        out_extra
);

    localparam int W = lpid_pkg::RES_W;

    logic              clr_active_reg;
    logic [AW-1:0]     clr_cnt_reg;
    logic [AW-1:0]     pix4_reg, pix5_reg, w1_pix_reg;
    logic              w1_valid_reg;
    logic [2:0][W-1:0] w1_res_reg, res5_reg, rd_data, new_res;
    lpid_pkg::chan8_t  q_next, color_reg;
    logic              writing5, fwd5, fwd1;
    logic              out_valid_reg;
    logic [7:0]        extra_reg;

    assign writing5 = ctl5.valid && cfg.dither_en;
    assign fwd5     = writing5 && (pix5_reg == pix4_reg);
    assign fwd1     = w1_valid_reg && (w1_pix_reg == pix4_reg);

    // residual banks, one per channel
    for (genvar k = 0; k < 3; k++)
    begin : g_res
        lpid_ram #(
            .WIDTH(W),
            .DEPTH(MAX_PIXELS)
        ) u_res (
            .clk   (clk),
            .we    (clr_active_reg || (en && writing5)),
            .waddr (clr_active_reg ? clr_cnt_reg : pix5_reg),
            .wdata (clr_active_reg ? '0 : new_res[k]),
            .re    (en),
            .raddr (pix3),
            .rdata (rd_data[k])
        );
    end

    // add residual, round to 8 bits with clamp, new residual
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            logic signed [17:0] sum, t;
            logic [7:0]         q;
            sum = $signed({2'b00, interp5[k]}) + 18'($signed(res5_reg[k]));
            t   = sum + 18'sd128;
            if (t < 0)
            begin
                q = 8'd0;
            end
            else if (t > 18'sd65535)
            begin
                q = 8'hFF;
            end
            else
            begin
                q = t[15:8];
            end
            q_next[k]  = q;
            new_res[k] = W'(sum - $signed({2'b00, q, q}));
        end
    end

    // clearing pass after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_cnt_reg    <= '0;
        end
        else if (clr_active_reg)
        begin
            clr_cnt_reg <= clr_cnt_reg + AW'(1);
            if (clr_cnt_reg == AW'(MAX_PIXELS - 1))
            begin
                clr_active_reg <= 1'b0;
            end
        end
    end

    // control: last write record and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            w1_valid_reg  <= writing5;
            out_valid_reg <= ctl5.valid;
        end
    end

    // residual capture with forwarding of the two writes the read missed
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pix4_reg   <= pix3;
            pix5_reg   <= pix4_reg;
            w1_pix_reg <= pix5_reg;
            w1_res_reg <= new_res;
            for (int k = 0; k < 3; k++)
            begin
                if (!cfg.dither_en)
                begin
                    res5_reg[k] <= '0;
                end
                else if (fwd5)
                begin
                    res5_reg[k] <= new_res[k];
                end
                else if (fwd1)
                begin
                    res5_reg[k] <= w1_res_reg[k];
                end
                else
                begin
                    res5_reg[k] <= rd_data[k];
                end
            end
            color_reg <= q_next;
            extra_reg <= ctl5.extra;
        end
    end

    assign clearing  = clr_active_reg;
    assign out_valid = out_valid_reg;
    assign out_color = color_reg;
    assign out_extra = extra_reg;

    // no pixel reaches the rounding stage while the store is being cleared
    a_no_pixel_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clr_active_reg |-> !ctl5.valid)
        else $error("pixel in flight during clearing pass");

    // residuals written back stay in their range
    a_res_range: assert property (@(posedge clk) disable iff (!rst_n)
        (writing5 && !clr_active_reg) |->
        ($signed(new_res[0]) >= -383 && $signed(new_res[0]) <= 127
         && $signed(new_res[1]) >= -383 && $signed(new_res[1]) <= 127
         && $signed(new_res[2]) >= -383 && $signed(new_res[2]) <= 127))
        else $error("residual out of range");

    // a stall freezes the output stage
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> ($stable(out_valid_reg) && $stable(color_reg)))
        else $error("output changed during stall");

endmodule
